>>> rtl/cwsc_pkg.sv
// shared constants, function codes and the result record of the sector cache directory
// no dependencies
`default_nettype none

package cwsc_pkg;

    localparam int ENTRIES_DEF = 64;
    localparam int SECTOR_W    = 32;
    localparam int SLOT_W      = 6;
    localparam int FUNC_W      = 2;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 48;

    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;

    typedef struct packed {
        logic                hit;
        logic [SLOT_W-1:0]   slot;
        logic                fetch_needed;
        logic                write_back;
        logic [SECTOR_W-1:0] write_back_sector;
        logic                last;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/cwsc_tag_ram.sv
// sector tag store: one write port, one read port, registered read data
// depends on cwsc_pkg for widths and default depth
`default_nettype none

module cwsc_tag_ram #(
    parameter int ENTRIES = cwsc_pkg::ENTRIES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [$clog2(ENTRIES)-1:0]    i_waddr,
    input  wire logic [cwsc_pkg::SECTOR_W-1:0] i_wdata,
    input  wire logic [$clog2(ENTRIES)-1:0]    i_raddr,
    output logic      [cwsc_pkg::SECTOR_W-1:0] o_rdata
);

    logic [cwsc_pkg::SECTOR_W-1:0] r_mem [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/clock_writeback_sector_cache.sv
// tag directory of a fully associative write-back sector cache, clock replacement
// one item at a time, the next accepted once a result is registered; one tag read per cycle
// hit at entry k: result once the scan compares entry k; miss: full scan, hand sweep to a victim, victim tag, result
// flush: walks entries up to the last dirty one, a tag read and a result per dirty entry; empty flush: one empty result
// synchronous reset clears state, valid/dirty/used flags, hand and output valid
// the tag ram is not cleared; a tag is only used for a valid entry
`default_nettype none

module clock_writeback_sector_cache #(
    parameter int ENTRIES = cwsc_pkg::ENTRIES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // tdata: func[1:0], sector[33:2], zero fill
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  wire logic [cwsc_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // tdata: hit[0], slot[6:1], fetch_needed[7], write_back[8],
    //        write_back_sector[40:9], zero fill
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    output logic      [cwsc_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic                                 o_m_axis_tlast
);

    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
    localparam int RES_W = $bits(cwsc_pkg::t_result) - 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_SWEEP = 7'b0000100,
        S_VTAG  = 7'b0001000,
        S_FLUSH = 7'b0010000,
        S_FTAG  = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    t_state r_state, n_state, r_after, n_after;
    logic [cwsc_pkg::FUNC_W-1:0]   r_func, n_func;
    logic [cwsc_pkg::SECTOR_W-1:0] r_sector, n_sector;
    logic [IW-1:0]                 r_idx, n_idx;
    logic                          r_chk, n_chk;
    logic [IW-1:0]                 r_chk_idx, n_chk_idx;
    logic [IW-1:0]                 r_hand, n_hand;
    logic [IW-1:0]                 r_vic, n_vic;
    logic [ENTRIES-1:0]            r_valid, n_valid;
    logic [ENTRIES-1:0]            r_dirty, n_dirty;
    logic [ENTRIES-1:0]            r_used, n_used;
    cwsc_pkg::t_result             r_res, n_res;
    cwsc_pkg::t_result             r_out, n_out;
    logic                          r_out_valid, n_out_valid;

    logic                          mem_we;
    logic [IW-1:0]                 mem_raddr;
    logic [cwsc_pkg::SECTOR_W-1:0] tag_rdata;
    logic [ENTRIES-1:0]            pending;
    logic                          later_dirty;
    logic                          out_free;
    logic                          vic_wb;
    logic [cwsc_pkg::FUNC_W-1:0]   in_func;

    cwsc_tag_ram #(
        .ENTRIES (ENTRIES)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_vic),
        .i_wdata (r_sector),
        .i_raddr (mem_raddr),
        .o_rdata (tag_rdata)
    );

    function automatic logic [IW-1:0] advance(input logic [IW-1:0] h);
        advance = (h == LAST_IDX) ? '0 : h + 1'b1;
    endfunction

    assign pending  = r_valid & r_dirty;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign in_func  = i_s_axis_tdata[cwsc_pkg::FUNC_W-1:0];
    assign vic_wb   = r_valid[r_vic] && r_dirty[r_vic];

    // any dirty entry above the current flush index
    always_comb begin
        later_dirty = 1'b0;
        for (int j = 0; j < ENTRIES; j++) begin
            if (j > int'(r_idx) && pending[j]) begin
                later_dirty = 1'b1;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_after     = r_after;
        n_func      = r_func;
        n_sector    = r_sector;
        n_idx       = r_idx;
        n_chk       = r_chk;
        n_chk_idx   = r_chk_idx;
        n_hand      = r_hand;
        n_vic       = r_vic;
        n_valid     = r_valid;
        n_dirty     = r_dirty;
        n_used      = r_used;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        mem_we      = 1'b0;
        mem_raddr   = r_idx;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    case (in_func)
                        cwsc_pkg::FUNC_READ, cwsc_pkg::FUNC_WRITE: begin
                            n_func   = in_func;
                            n_sector = i_s_axis_tdata[cwsc_pkg::FUNC_W +: cwsc_pkg::SECTOR_W];
                            n_idx    = '0;
                            n_chk    = 1'b0;
                            n_state  = S_SCAN;
                        end
                        cwsc_pkg::FUNC_FLUSH: begin
                            if (pending == '0) begin
                                n_res      = '0;
                                n_res.last = 1'b1;
                                n_after    = S_IDLE;
                                n_state    = S_EMIT;
                            end else begin
                                n_idx   = '0;
                                n_state = S_FLUSH;
                            end
                        end
                        default: begin
                            // undefined code: dropped without a result
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // compare the tag read last cycle while the next one is read
                if (r_chk && r_valid[r_chk_idx] && tag_rdata == r_sector) begin
                    n_used[r_chk_idx] = 1'b1;
                    if (r_func == cwsc_pkg::FUNC_WRITE) begin
                        n_dirty[r_chk_idx] = 1'b1;
                    end
                    n_res      = '0;
                    n_res.hit  = 1'b1;
                    n_res.slot = cwsc_pkg::SLOT_W'(r_chk_idx);
                    n_res.last = 1'b1;
                    n_after    = S_IDLE;
                    n_state    = S_EMIT;
                end else if (r_chk && r_chk_idx == LAST_IDX) begin
                    n_state = S_SWEEP;
                end else begin
                    n_chk     = 1'b1;
                    n_chk_idx = r_idx;
                    n_idx     = r_idx + 1'b1;
                end
            end
            S_SWEEP: begin
                mem_raddr = r_hand;
                n_hand    = advance(r_hand);
                if (!r_valid[r_hand] || !r_used[r_hand]) begin
                    n_vic   = r_hand;
                    n_state = S_VTAG;
                end else begin
                    n_used[r_hand] = 1'b0;
                end
            end
            S_VTAG: begin
                // victim tag is on the read port; install the new tag
                n_res                   = '0;
                n_res.slot              = cwsc_pkg::SLOT_W'(r_vic);
                n_res.fetch_needed      = (r_func == cwsc_pkg::FUNC_READ);
                n_res.write_back        = vic_wb;
                n_res.write_back_sector = vic_wb ? tag_rdata : '0;
                n_res.last              = 1'b1;
                mem_we                  = 1'b1;
                n_valid[r_vic]          = 1'b1;
                n_used[r_vic]           = 1'b1;
                n_dirty[r_vic]          = (r_func == cwsc_pkg::FUNC_WRITE);
                n_after                 = S_IDLE;
                n_state                 = S_EMIT;
            end
            S_FLUSH: begin
                if (pending[r_idx]) begin
                    n_state = S_FTAG;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_FTAG: begin
                n_res                   = '0;
                n_res.slot              = cwsc_pkg::SLOT_W'(r_idx);
                n_res.write_back        = 1'b1;
                n_res.write_back_sector = tag_rdata;
                n_res.last              = !later_dirty;
                n_dirty[r_idx]          = 1'b0;
                n_idx                   = r_idx + 1'b1;
                n_after                 = later_dirty ? S_FLUSH : S_IDLE;
                n_state                 = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = r_after;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_after     <= S_IDLE;
            r_hand      <= '0;
            r_valid     <= '0;
            r_dirty     <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
            r_chk       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_after     <= n_after;
            r_hand      <= n_hand;
            r_valid     <= n_valid;
            r_dirty     <= n_dirty;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
            r_chk       <= n_chk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_sector  <= n_sector;
        r_idx     <= n_idx;
        r_chk_idx <= n_chk_idx;
        r_vic     <= n_vic;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out.last;
    assign o_m_axis_tdata  = {{(cwsc_pkg::OUT_DATA_W - RES_W){1'b0}},
                              r_out.write_back_sector, r_out.write_back,
                              r_out.fetch_needed, r_out.slot, r_out.hit};

    // a hit never asks for a fetch or a write-back
    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.hit) |-> (!r_out.fetch_needed && !r_out.write_back))
        else $error("hit result carries fetch or write-back");

    // write-back sector is zero unless a write-back is reported
    a_wbs_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.write_back) |-> (r_out.write_back_sector == '0))
        else $error("write-back sector set without write-back");

    // the hand never leaves the entry range
    a_hand_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hand <= LAST_IDX)
        else $error("clock hand out of range");

    // an installed victim is valid and used afterwards
    a_install: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_VTAG) |=> (r_valid[r_vic] && r_used[r_vic]))
        else $error("victim not installed");

    // a non-final flush transfer returns to the flush walk
    a_flush_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free && !r_res.last) |=> (r_state == S_FLUSH))
        else $error("flush ended before its last result");

endmodule

`default_nettype wire

>>> tb/tb_clock_writeback_sector_cache.sv
// self-checking testbench for the clock-replacement write-back sector cache directory
// depends on cwsc_pkg and clock_writeback_sector_cache; stream driver and monitor in one module
`timescale 1ns / 1ps

module tb_clock_writeback_sector_cache;

    localparam int NUM_SLOTS = cwsc_pkg::ENTRIES_DEF;
    localparam int POOL_SIZE = 128;
    localparam int LONG_HOLD = 400;
    localparam int DRAIN_CYCLES = 400;
    localparam int CYCLE_LIMIT = 10000000;
    localparam logic [cwsc_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [cwsc_pkg::FUNC_W-1:0]   func;
        logic [cwsc_pkg::SECTOR_W-1:0] sector;
    } t_request;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic [cwsc_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                            m_tready = 1'b0;
    logic                            o_s_axis_tready;
    logic                            o_m_axis_tvalid;
    logic [cwsc_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                            o_m_axis_tlast;

    // directory mirror
    bit [cwsc_pkg::SECTOR_W-1:0] mirror_tag [NUM_SLOTS];
    bit                mirror_valid [NUM_SLOTS];
    bit                mirror_dirty [NUM_SLOTS];
    bit                mirror_used [NUM_SLOTS];
    int unsigned       mirror_hand = 0;

    t_request          request_queue[$];
    cwsc_pkg::t_result pending_replies[$];
    logic [cwsc_pkg::SECTOR_W-1:0] sector_pool [POOL_SIZE];

    int  error_count = 0;
    int  reply_count = 0;
    int  cycle_count = 0;
    int  tx_gap = 0;
    int  rx_stall = 0;
    bit  tx_burst = 1'b0;
    bit  rx_burst = 1'b0;
    bit  hold_done = 1'b0;

    clock_writeback_sector_cache DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),         // func[1:0], sector[33:2], zero fill
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // hit, slot, fetch_needed, write_back, wb sector
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    // mostly short gaps, a few long ones, none while in a burst stretch
    function automatic int idle_len(input bit burst);
        int unsigned r;
        if (burst) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 82) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(25, 90);
    endfunction

    // updates the directory mirror and queues the replies of one request
    task automatic lookup_and_replace(input logic [cwsc_pkg::FUNC_W-1:0] func,
                                      input logic [cwsc_pkg::SECTOR_W-1:0] sector);
        cwsc_pkg::t_result r;
        cwsc_pkg::t_result held;
        bit          have_held;
        bit          found;
        int unsigned idx;
        int unsigned steps;
        r = '0;
        held = '0;
        have_held = 1'b0;
        found = 1'b0;
        if (func == FUNC_UNUSED) begin
            return;
        end
        if (func == cwsc_pkg::FUNC_FLUSH) begin
            for (idx = 0; idx < NUM_SLOTS; idx++) begin
                if (mirror_valid[idx] && mirror_dirty[idx]) begin
                    if (have_held) pending_replies.push_back(held);
                    held = '0;
                    held.slot = cwsc_pkg::SLOT_W'(idx);
                    held.write_back = 1'b1;
                    held.write_back_sector = mirror_tag[idx];
                    have_held = 1'b1;
                    mirror_dirty[idx] = 1'b0;
                end
            end
            // nothing dirty still yields one empty reply
            held.last = 1'b1;
            pending_replies.push_back(held);
            return;
        end
        for (idx = 0; idx < NUM_SLOTS && !found; idx++) begin
            if (mirror_valid[idx] && mirror_tag[idx] == sector) begin
                found = 1'b1;
                mirror_used[idx] = 1'b1;
                if (func == cwsc_pkg::FUNC_WRITE) mirror_dirty[idx] = 1'b1;
                r.hit = 1'b1;
                r.slot = cwsc_pkg::SLOT_W'(idx);
            end
        end
        if (!found) begin
            // second-chance sweep from the hand
            idx = mirror_hand;
            for (steps = 0; steps <= 2 * NUM_SLOTS && !found; steps++) begin
                if (!mirror_valid[idx] || !mirror_used[idx]) begin
                    found = 1'b1;
                end else begin
                    mirror_used[idx] = 1'b0;
                    idx = (idx + 1) % NUM_SLOTS;
                end
            end
            mirror_hand = (idx + 1) % NUM_SLOTS;
            r.slot = cwsc_pkg::SLOT_W'(idx);
            r.fetch_needed = (func == cwsc_pkg::FUNC_READ);
            if (mirror_valid[idx] && mirror_dirty[idx]) begin
                r.write_back = 1'b1;
                r.write_back_sector = mirror_tag[idx];
            end
            mirror_tag[idx] = sector;
            mirror_valid[idx] = 1'b1;
            mirror_used[idx] = 1'b1;
            mirror_dirty[idx] = (func == cwsc_pkg::FUNC_WRITE);
        end
        r.last = 1'b1;
        pending_replies.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        t_request req;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            tx_gap <= 0;
        end else begin
            if (s_tvalid && o_s_axis_tready) begin
                lookup_and_replace(s_tdata[1:0], s_tdata[33:2]);
                if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
            end
            if (!s_tvalid || o_s_axis_tready) begin
                if (tx_gap > 0) begin
                    tx_gap <= tx_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (request_queue.size() > 0) begin
                    req = request_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {6'b0, req.sector, req.func};
                    tx_gap <= idle_len(tx_burst);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // reply monitor and receiver back-pressure
    always @(posedge i_clk) begin
        cwsc_pkg::t_result want;
        cwsc_pkg::t_result got;
        int      k;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            rx_stall <= 0;
        end else begin
            if (o_m_axis_tvalid && m_tready) begin
                got = '0;
                got.hit = o_m_axis_tdata[0];
                got.slot = o_m_axis_tdata[6:1];
                got.fetch_needed = o_m_axis_tdata[7];
                got.write_back = o_m_axis_tdata[8];
                got.write_back_sector = o_m_axis_tdata[40:9];
                got.last = o_m_axis_tlast;
                reply_count++;
                if (pending_replies.size() == 0) begin
                    $display("%0t: unexpected transfer, expected none actual %h last %b",
                             $time, o_m_axis_tdata, o_m_axis_tlast);
                    error_count++;
                end else begin
                    want = pending_replies.pop_front();
                    check_field("hit", 32'(want.hit), 32'(got.hit));
                    check_field("slot", 32'(want.slot), 32'(got.slot));
                    check_field("fetch_needed", 32'(want.fetch_needed),
                                32'(got.fetch_needed));
                    check_field("write_back", 32'(want.write_back), 32'(got.write_back));
                    check_field("write_back_sector", want.write_back_sector,
                                got.write_back_sector);
                    check_field("last", 32'(want.last), 32'(got.last));
                end
                if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
            end
            if (rx_stall > 0) begin
                rx_stall <= rx_stall - 1;
                m_tready <= 1'b0;
            end else if (!hold_done && reply_count >= 60) begin
                // long hold so the block backs up and stalls its input
                hold_done = 1'b1;
                rx_stall <= LONG_HOLD;
                m_tready <= 1'b0;
            end else if (rx_burst || $urandom_range(0, 2) != 0) begin
                m_tready <= 1'b1;
            end else begin
                k = idle_len(1'b0);
                if (k == 0) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    rx_stall <= k - 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("clock_writeback_sector_cache: mismatch");
            $finish;
        end
    end

    task automatic queue_request(input logic [cwsc_pkg::FUNC_W-1:0] func,
                                 input logic [cwsc_pkg::SECTOR_W-1:0] sector);
        t_request req;
        req.func = func;
        req.sector = sector;
        request_queue.push_back(req);
    endtask

    task automatic wait_idle();
        while (request_queue.size() != 0 || s_tvalid || pending_replies.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int          pool_hi [4];
        int          made;
        int unsigned r;
        logic [cwsc_pkg::SECTOR_W-1:0] sec;
        pool_hi = '{40, 72, 110, 64};
        for (int i = 0; i < POOL_SIZE; i++) sector_pool[i] = $urandom;
        sector_pool[0] = '0;
        sector_pool[1] = '1;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty flush, hits and misses, extremes, ignored code, dirty flush
        queue_request(cwsc_pkg::FUNC_FLUSH, 32'h0000_0000);
        queue_request(cwsc_pkg::FUNC_READ, 32'h0000_0000);
        queue_request(cwsc_pkg::FUNC_READ, 32'h0000_0000);
        queue_request(cwsc_pkg::FUNC_WRITE, 32'hFFFF_FFFF);
        queue_request(cwsc_pkg::FUNC_WRITE, 32'h0000_0000);
        queue_request(cwsc_pkg::FUNC_READ, 32'h5555_5555);
        queue_request(cwsc_pkg::FUNC_WRITE, 32'hAAAA_AAAA);
        queue_request(FUNC_UNUSED, 32'h1234_5678);
        queue_request(cwsc_pkg::FUNC_WRITE, 32'hFFFF_FFFF);
        queue_request(cwsc_pkg::FUNC_FLUSH, 32'hDEAD_BEEF);
        queue_request(cwsc_pkg::FUNC_FLUSH, 32'hFFFF_FFFF);
        queue_request(cwsc_pkg::FUNC_READ, 32'hFFFF_FFFF);
        queue_request(FUNC_UNUSED, 32'hFFFF_FFFF);
        queue_request(cwsc_pkg::FUNC_WRITE, 32'h0000_0001);
        queue_request(cwsc_pkg::FUNC_WRITE, 32'h8000_0000);
        queue_request(cwsc_pkg::FUNC_READ, 32'h7FFF_FFFF);
        queue_request(cwsc_pkg::FUNC_READ, 32'h8000_0000);
        queue_request(cwsc_pkg::FUNC_WRITE, 32'h5555_5555);
        queue_request(cwsc_pkg::FUNC_FLUSH, 32'h0000_0000);
        queue_request(cwsc_pkg::FUNC_READ, 32'hAAAA_AAAA);
        wait_idle();

        // random phases over sector pools of differing size: some fit, some evict
        for (int p = 0; p < 4; p++) begin
            made = 0;
            while (made < 90) begin
                r = $urandom_range(0, 99);
                if ($urandom_range(0, 9) == 0) sec = $urandom;
                else sec = sector_pool[$urandom_range(0, pool_hi[p] - 1)];
                if (r < 3) begin
                    queue_request(FUNC_UNUSED, sec);
                end else begin
                    if (r < 10) queue_request(cwsc_pkg::FUNC_FLUSH, sec);
                    else if (r < 55) queue_request(cwsc_pkg::FUNC_READ, sec);
                    else queue_request(cwsc_pkg::FUNC_WRITE, sec);
                    made++;
                end
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_replies.size() == 0) begin
            $display("clock_writeback_sector_cache: match");
        end else begin
            $display("clock_writeback_sector_cache: mismatch");
        end
        $finish;
    end

endmodule
